/* hdl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Payload structs, the command passed from the scanner front to the output
// back end, state enums and character codes.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  token_char;
        logic        last_of_token;
        logic [2:0]  error_code;
        logic [15:0] line_number;
        logic        word_truncated;
    } t_out_item;

    // one command: either a single result or a drain of the token store
    typedef struct packed {
        logic        is_drain;
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [2:0]  err;
        logic        trunc;
        logic [15:0] line;
    } t_cmd;

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_WORD,
        M_NUMBER,
        M_ENDED,
        M_ERROR
    } t_scan_mode;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } t_back_state;

    localparam logic [2:0] K_WORD    = 3'd0;
    localparam logic [2:0] K_NUMBER  = 3'd1;
    localparam logic [2:0] K_SPECIAL = 3'd2;
    localparam logic [2:0] K_END     = 3'd3;
    localparam logic [2:0] K_ERROR   = 3'd4;

    localparam logic [2:0] E_NONE          = 3'd0;
    localparam logic [2:0] E_EOF_COMMENT   = 3'd1;
    localparam logic [2:0] E_BRACE_START   = 3'd2;
    localparam logic [2:0] E_DOUBLE_US     = 3'd3;
    localparam logic [2:0] E_TRAILING_US   = 3'd4;
    localparam logic [2:0] E_ILLEGAL       = 3'd5;
    localparam logic [2:0] E_NUMBER_LONG   = 3'd6;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_US      = 8'h5F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [15:0] LINE_MAX   = 16'hFFFF;
    localparam logic [15:0] LINE_FIRST = 16'd1;

    localparam logic [3:0] KEEP_RESET = 4'd15;
    localparam logic       REG_WORD_KEEP = 1'b0;

endpackage

/* hdl/stt_ram.sv */
// ----------------------------------------------------------------------------
// stt_ram: generic single write, single read ram
// One write port and one read port, read data registered and held while
// no read is enabled.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 15,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/stt_front.sv */
// ----------------------------------------------------------------------------
// stt_front: scanner front end
// Accepts source bytes, tracks the scan mode, fills the token store and
// queues commands for the back end.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int TOKEN_CHARS = 15,
    localparam int LW = $clog2(TOKEN_CHARS + 1),
    localparam int AW = (TOKEN_CHARS > 1) ? $clog2(TOKEN_CHARS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  stt_pkg::t_in_item i_item,
    input  logic [3:0]        i_keep_len,
    input  logic              i_q_full,
    output logic              o_push,
    output stt_pkg::t_cmd     o_cmd,
    output logic [LW-1:0]     o_drain_len,
    input  logic              i_drain_done,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [7:0]        o_wr_data
);

    localparam int KW = (LW > 4) ? LW : 4;

    stt_pkg::t_scan_mode r_mode, n_mode;
    logic [LW-1:0]       r_len, n_len;
    logic                r_prev_us, n_prev_us;
    logic                r_overlong, n_overlong;
    logic [15:0]         r_line, n_line;
    logic                r_wait, n_wait;
    logic                r_drain_busy, n_drain_busy;
    logic [7:0]          r_hold_byte, n_hold_byte;
    logic                r_hold_eoi, n_hold_eoi;
    logic [15:0]         r_hold_line, n_hold_line;

    logic          accept, go;
    logic [7:0]    b;
    logic          eoi;
    logic [15:0]   cur_line;
    logic          is_lower, is_digit, is_space, is_special;
    logic          do_idle;
    logic [KW-1:0] keep_ext, keep_lim;

    assign o_stall = r_wait || r_drain_busy || i_q_full;
    assign accept  = i_valid && !o_stall;
    assign go      = r_wait && !r_drain_busy && !i_q_full;

    assign b        = r_wait ? r_hold_byte : i_item.source_byte;
    assign eoi      = r_wait ? r_hold_eoi
                             : (i_item.end_of_input || (i_item.source_byte == stt_pkg::CH_DOLLAR));
    assign cur_line = r_wait ? r_hold_line : r_line;

    assign is_lower   = (b >= 8'h61) && (b <= 8'h7A);
    assign is_digit   = (b >= 8'h30) && (b <= 8'h39);
    assign is_space   = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    assign is_special = (b == 8'h3A) || (b == 8'h2C) || (b == 8'h3B) || (b == 8'h3D)
                     || (b == 8'h2B) || (b == 8'h2D) || (b == 8'h2E);

    // kept word length: zero counts as one, capped at the store depth
    assign keep_ext = (i_keep_len == 4'd0) ? KW'(1) : KW'(i_keep_len);
    assign keep_lim = (keep_ext > KW'(TOKEN_CHARS)) ? KW'(TOKEN_CHARS) : keep_ext;

    assign o_drain_len = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= stt_pkg::M_IDLE;
            r_len        <= '0;
            r_prev_us    <= 1'b0;
            r_overlong   <= 1'b0;
            r_line       <= stt_pkg::LINE_FIRST;
            r_wait       <= 1'b0;
            r_drain_busy <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_len        <= n_len;
            r_prev_us    <= n_prev_us;
            r_overlong   <= n_overlong;
            r_line       <= n_line;
            r_wait       <= n_wait;
            r_drain_busy <= n_drain_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_byte <= n_hold_byte;
        r_hold_eoi  <= n_hold_eoi;
        r_hold_line <= n_hold_line;
    end

    always_comb begin
        n_mode       = r_mode;
        n_len        = r_len;
        n_prev_us    = r_prev_us;
        n_overlong   = r_overlong;
        n_line       = r_line;
        n_wait       = r_wait;
        n_drain_busy = r_drain_busy && !i_drain_done;
        n_hold_byte  = r_hold_byte;
        n_hold_eoi   = r_hold_eoi;
        n_hold_line  = r_hold_line;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_cmd.line   = cur_line;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_len[AW-1:0];
        o_wr_data    = b;
        do_idle      = 1'b0;

        if (go) begin
            n_wait  = 1'b0;
            do_idle = 1'b1;
        end else if (accept) begin
            unique case (r_mode)
                stt_pkg::M_IDLE: begin
                    do_idle = 1'b1;
                end
                stt_pkg::M_COMMENT: begin
                    if (eoi) begin
                        o_push     = 1'b1;
                        o_cmd.kind = stt_pkg::K_ERROR;
                        o_cmd.err  = stt_pkg::E_EOF_COMMENT;
                        n_mode     = stt_pkg::M_ERROR;
                    end else if (b == stt_pkg::CH_RBRACE) begin
                        n_mode = stt_pkg::M_IDLE;
                    end
                end
                stt_pkg::M_WORD: begin
                    if (!eoi && (is_lower || is_digit || (b == stt_pkg::CH_US))) begin
                        if ((b == stt_pkg::CH_US) && r_prev_us) begin
                            o_push     = 1'b1;
                            o_cmd.kind = stt_pkg::K_ERROR;
                            o_cmd.err  = stt_pkg::E_DOUBLE_US;
                            n_mode     = stt_pkg::M_ERROR;
                        end else begin
                            if (KW'(r_len) < keep_lim) begin
                                o_wr_en = 1'b1;
                                n_len   = r_len + LW'(1);
                            end else begin
                                n_overlong = 1'b1;
                            end
                            n_prev_us = (b == stt_pkg::CH_US);
                        end
                    end else if (r_prev_us) begin
                        o_push     = 1'b1;
                        o_cmd.kind = stt_pkg::K_ERROR;
                        o_cmd.err  = stt_pkg::E_TRAILING_US;
                        n_mode     = stt_pkg::M_ERROR;
                    end else begin
                        o_push         = 1'b1;
                        o_cmd.is_drain = 1'b1;
                        o_cmd.kind     = stt_pkg::K_WORD;
                        o_cmd.trunc    = r_overlong;
                        n_drain_busy   = 1'b1;
                        n_mode         = stt_pkg::M_IDLE;
                        n_wait         = 1'b1;
                    end
                end
                stt_pkg::M_NUMBER: begin
                    if (!eoi && is_digit) begin
                        if (r_len >= LW'(TOKEN_CHARS)) begin
                            o_push     = 1'b1;
                            o_cmd.kind = stt_pkg::K_ERROR;
                            o_cmd.err  = stt_pkg::E_NUMBER_LONG;
                            n_mode     = stt_pkg::M_ERROR;
                        end else begin
                            o_wr_en = 1'b1;
                            n_len   = r_len + LW'(1);
                        end
                    end else begin
                        o_push         = 1'b1;
                        o_cmd.is_drain = 1'b1;
                        o_cmd.kind     = stt_pkg::K_NUMBER;
                        n_drain_busy   = 1'b1;
                        n_mode         = stt_pkg::M_IDLE;
                        n_wait         = 1'b1;
                    end
                end
                stt_pkg::M_ENDED, stt_pkg::M_ERROR: begin
                end
                default: begin
                end
            endcase

            // delimiter byte is replayed once the store has drained
            if (n_wait) begin
                n_hold_byte = b;
                n_hold_eoi  = eoi;
                n_hold_line = r_line;
            end

            if ((r_mode != stt_pkg::M_ENDED) && (r_mode != stt_pkg::M_ERROR) && !eoi
                && (b == stt_pkg::CH_NEWLINE) && (r_line != stt_pkg::LINE_MAX)) begin
                n_line = r_line + 16'd1;
            end
        end

        if (do_idle) begin
            priority if (eoi) begin
                o_push     = 1'b1;
                o_cmd.kind = stt_pkg::K_END;
                o_cmd.ch   = stt_pkg::CH_DOLLAR;
                n_mode     = stt_pkg::M_ENDED;
            end else if (b == stt_pkg::CH_LBRACE) begin
                n_mode = stt_pkg::M_COMMENT;
            end else if (b == stt_pkg::CH_RBRACE) begin
                o_push     = 1'b1;
                o_cmd.kind = stt_pkg::K_ERROR;
                o_cmd.err  = stt_pkg::E_BRACE_START;
                n_mode     = stt_pkg::M_ERROR;
            end else if (is_space) begin
                n_mode = stt_pkg::M_IDLE;
            end else if (is_special) begin
                o_push     = 1'b1;
                o_cmd.kind = stt_pkg::K_SPECIAL;
                o_cmd.ch   = b;
            end else if (is_lower || is_digit) begin
                o_wr_en    = 1'b1;
                o_wr_addr  = '0;
                n_len      = LW'(1);
                n_prev_us  = 1'b0;
                n_overlong = 1'b0;
                n_mode     = is_lower ? stt_pkg::M_WORD : stt_pkg::M_NUMBER;
            end else begin
                o_push     = 1'b1;
                o_cmd.kind = stt_pkg::K_ERROR;
                o_cmd.err  = stt_pkg::E_ILLEGAL;
                n_mode     = stt_pkg::M_ERROR;
            end
        end
    end

endmodule

/* hdl/stt_queue.sv */
// ----------------------------------------------------------------------------
// stt_queue: two-entry command queue
// Decouples the scanner front end from the result back end.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stt_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output stt_pkg::t_cmd o_head
);

    stt_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/stt_back.sv */
// ----------------------------------------------------------------------------
// stt_back: result back end
// Turns queued commands into result transactions, reading token characters
// out of the token store one per cycle into the output register while the output does not stall.
// ----------------------------------------------------------------------------
module stt_back #(
    parameter int TOKEN_CHARS = 15,
    localparam int LW = $clog2(TOKEN_CHARS + 1),
    localparam int AW = (TOKEN_CHARS > 1) ? $clog2(TOKEN_CHARS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  stt_pkg::t_cmd      i_q_head,
    output logic               o_pop,
    input  logic [LW-1:0]      i_drain_len,
    output logic               o_drain_done,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  logic [7:0]         i_rd_data,
    output logic               o_valid,
    input  logic               i_stall,
    output stt_pkg::t_out_item o_item
);

    stt_pkg::t_back_state r_state, n_state;
    logic [LW-1:0]        r_idx, n_idx;
    logic [2:0]           r_kind, n_kind;
    logic                 r_trunc, n_trunc;
    logic [15:0]          r_line, n_line;
    logic                 r_out_valid, n_out_valid;
    stt_pkg::t_out_item   r_out, n_out;
    logic                 out_free;
    logic                 is_last;

    assign out_free = !r_out_valid || !i_stall;
    assign is_last  = ((r_idx + LW'(1)) == i_drain_len);
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stt_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_trunc <= n_trunc;
        r_line  <= n_line;
        r_out   <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_kind       = r_kind;
        n_trunc      = r_trunc;
        n_line       = r_line;
        n_out_valid  = r_out_valid && i_stall;
        n_out        = r_out;
        o_pop        = 1'b0;
        o_drain_done = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;

        unique case (r_state)
            stt_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head.is_drain) begin
                        o_pop     = 1'b1;
                        o_rd_en   = 1'b1;
                        n_idx     = '0;
                        n_kind    = i_q_head.kind;
                        n_trunc   = i_q_head.trunc;
                        n_line    = i_q_head.line;
                        n_state   = stt_pkg::B_EMIT;
                    end else if (out_free) begin
                        o_pop                = 1'b1;
                        n_out_valid          = 1'b1;
                        n_out.token_kind     = i_q_head.kind;
                        n_out.token_char     = i_q_head.ch;
                        n_out.last_of_token  = 1'b1;
                        n_out.error_code     = i_q_head.err;
                        n_out.line_number    = i_q_head.line;
                        n_out.word_truncated = 1'b0;
                    end
                end
            end
            stt_pkg::B_EMIT: begin
                // read data stays put while the output register is full and stalled
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.token_kind     = r_kind;
                    n_out.token_char     = i_rd_data;
                    n_out.last_of_token  = is_last;
                    n_out.error_code     = stt_pkg::E_NONE;
                    n_out.line_number    = r_line;
                    n_out.word_truncated = r_trunc;
                    if (is_last) begin
                        o_drain_done = 1'b1;
                        n_state      = stt_pkg::B_IDLE;
                    end else begin
                        n_idx     = r_idx + LW'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = n_idx[AW-1:0];
                    end
                end
            end
            default: begin
                n_state = stt_pkg::B_IDLE;
            end
        endcase
    end

endmodule

/* hdl/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte stream to token stream
// Front end scans bytes and fills the token store, back end emits one result
// transaction per token character or error, with a short command queue between.
// ----------------------------------------------------------------------------
// path: a special, end or error result passes the command queue and the output
//   register; a word or number follows its delimiter, through the queue, the
//   token store read register and the output register
// throughput: one byte per cycle while no token is being drained and the command
//   queue has room; a word or number that ends holds the input while the back
//   end reads the token store one character per cycle while the output flows
// reset: synchronous active low; clears scan state, line count to one, keep
//   length to 15; the token store is not cleared
module source_text_tokenizer #(
    parameter int TOKEN_CHARS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stt_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam int AW = (TOKEN_CHARS > 1) ? $clog2(TOKEN_CHARS) : 1;

    logic [3:0]    r_keep_len;
    logic          cfg_wr;
    logic          q_push, q_full, q_pop, q_empty;
    stt_pkg::t_cmd q_in, q_head;
    logic [LW-1:0] drain_len;
    logic          drain_done;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == stt_pkg::REG_WORD_KEEP);
    assign prdata = (paddr[2] == stt_pkg::REG_WORD_KEEP) ? {28'd0, r_keep_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_len <= stt_pkg::KEEP_RESET;
        end else if (cfg_wr) begin
            r_keep_len <= pwdata[3:0];
        end
    end

    stt_front #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (i_in_item),
        .i_keep_len   (r_keep_len),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in),
        .o_drain_len  (drain_len),
        .i_drain_done (drain_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    stt_ram #(
        .WIDTH (8),
        .DEPTH (TOKEN_CHARS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    stt_back #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_pop        (q_pop),
        .i_drain_len  (drain_len),
        .o_drain_done (drain_done),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_item       (o_out_item)
    );

endmodule

/* sim/source_text_tokenizer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: self-checking bench for the source text tokenizer
// Streams source bytes through the valid/stall input, predicts every token
// character, end and error transaction, and compares the output field by field.
// Covers the keep length extremes, comments, whitespace and one terminal
// case per run, chosen at random.
// ----------------------------------------------------------------------------

localparam int MAX_CHARS = 15;

localparam logic [7:0] CH_TAB   = 8'h09;
localparam logic [7:0] CH_VTAB  = 8'h0B;
localparam logic [7:0] CH_FFEED = 8'h0C;
localparam logic [7:0] CH_CR    = 8'h0D;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_TOP   = 8'hFF;

class token_checker;
    stt_pkg::t_out_item  expected_chars[$];
    stt_pkg::t_scan_mode mode;
    logic [7:0]          token_chars [MAX_CHARS];
    int unsigned         char_count;
    bit                  after_us;
    bit                  too_long;
    logic [15:0]         line;
    logic [3:0]          keep;
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         bytes_seen;

    function new();
        mode = stt_pkg::M_IDLE;
        char_count = 0;
        after_us = 1'b0;
        too_long = 1'b0;
        line = stt_pkg::LINE_FIRST;
        keep = stt_pkg::KEEP_RESET;
        mismatches = 0;
        checked = 0;
        bytes_seen = 0;
    endfunction

    function void set_keep(logic [3:0] v);
        keep = v;
    endfunction

    function bit busy();
        return expected_chars.size() != 0;
    endfunction

    function bit is_lower(logic [7:0] b);
        return b >= "a" && b <= "z";
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function bit is_space(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == stt_pkg::CH_NEWLINE || b == CH_VTAB ||
               b == CH_FFEED || b == CH_CR;
    endfunction

    function bit is_special(logic [7:0] b);
        return b == ":" || b == "," || b == ";" || b == "=" || b == "+" || b == "-" ||
               b == ".";
    endfunction

    // zero keeps one character
    function int unsigned keep_limit();
        int unsigned k;
        k = keep;
        if (k == 0) k = 1;
        if (k > MAX_CHARS) k = MAX_CHARS;
        return k;
    endfunction

    function void push(logic [2:0] kind, logic [7:0] ch, bit last, logic [2:0] err,
                       bit trunc);
        stt_pkg::t_out_item r;
        r.token_kind = kind;
        r.token_char = ch;
        r.last_of_token = last;
        r.error_code = err;
        r.line_number = line;
        r.word_truncated = trunc;
        expected_chars.insert(expected_chars.size(), r);
    endfunction

    function void raise_error(logic [2:0] code);
        push(stt_pkg::K_ERROR, stt_pkg::CH_NUL, 1'b1, code, 1'b0);
        mode = stt_pkg::M_ERROR;
    endfunction

    function void flush_token(logic [2:0] kind, bit trunc);
        int unsigned i;
        for (i = 0; i < char_count && i < MAX_CHARS; i++)
            push(kind, token_chars[i], (i + 1 == char_count), stt_pkg::E_NONE, trunc);
        mode = stt_pkg::M_IDLE;
    endfunction

    function void start_token(stt_pkg::t_scan_mode m, logic [7:0] b);
        mode = m;
        token_chars[0] = b;
        char_count = 1;
        after_us = 1'b0;
        too_long = 1'b0;
    endfunction

    function void scan_between(logic [7:0] b, bit eoi);
        if (eoi) begin
            push(stt_pkg::K_END, stt_pkg::CH_DOLLAR, 1'b1, stt_pkg::E_NONE, 1'b0);
            mode = stt_pkg::M_ENDED;
        end else if (b == stt_pkg::CH_LBRACE) begin
            mode = stt_pkg::M_COMMENT;
        end else if (b == stt_pkg::CH_RBRACE) begin
            raise_error(stt_pkg::E_BRACE_START);
        end else if (is_space(b)) begin
            // skipped
        end else if (is_special(b)) begin
            push(stt_pkg::K_SPECIAL, b, 1'b1, stt_pkg::E_NONE, 1'b0);
        end else if (is_lower(b)) begin
            start_token(stt_pkg::M_WORD, b);
        end else if (is_digit(b)) begin
            start_token(stt_pkg::M_NUMBER, b);
        end else begin
            raise_error(stt_pkg::E_ILLEGAL);
        end
    endfunction

    function void predict_item(stt_pkg::t_in_item it);
        logic [7:0] b;
        bit eoi;
        b = it.source_byte;
        eoi = it.end_of_input || (b == stt_pkg::CH_DOLLAR);
        bytes_seen++;
        if (mode == stt_pkg::M_ERROR || mode == stt_pkg::M_ENDED) return;
        case (mode)
            stt_pkg::M_COMMENT: begin
                if (eoi) raise_error(stt_pkg::E_EOF_COMMENT);
                else if (b == stt_pkg::CH_RBRACE) mode = stt_pkg::M_IDLE;
            end
            stt_pkg::M_WORD: begin
                if (!eoi && (is_lower(b) || is_digit(b) || b == stt_pkg::CH_US)) begin
                    if (b == stt_pkg::CH_US && after_us) begin
                        raise_error(stt_pkg::E_DOUBLE_US);
                    end else begin
                        if (char_count < keep_limit()) begin
                            token_chars[char_count] = b;
                            char_count++;
                        end else begin
                            too_long = 1'b1;
                        end
                        after_us = (b == stt_pkg::CH_US);
                    end
                end else if (after_us) begin
                    raise_error(stt_pkg::E_TRAILING_US);
                end else begin
                    // delimiter ends the word and is then scanned on its own
                    flush_token(stt_pkg::K_WORD, too_long);
                    scan_between(b, eoi);
                end
            end
            stt_pkg::M_NUMBER: begin
                if (!eoi && is_digit(b)) begin
                    if (char_count >= MAX_CHARS) begin
                        raise_error(stt_pkg::E_NUMBER_LONG);
                    end else begin
                        token_chars[char_count] = b;
                        char_count++;
                    end
                end else begin
                    flush_token(stt_pkg::K_NUMBER, 1'b0);
                    scan_between(b, eoi);
                end
            end
            default: scan_between(b, eoi);
        endcase
        if (!eoi && b == stt_pkg::CH_NEWLINE && line != stt_pkg::LINE_MAX) line++;
    endfunction

    function void report(string what, bit have_want, stt_pkg::t_out_item want,
                         stt_pkg::t_out_item got);
        mismatches++;
        if (mismatches > 10) return;
        if (have_want)
            $display("%0t %s: expected kind=%0d char=%02h last=%0b err=%0d line=%0d trunc=%0b",
                     $time, what, want.token_kind, want.token_char, want.last_of_token,
                     want.error_code, want.line_number, want.word_truncated);
        $display("%0t %s: got      kind=%0d char=%02h last=%0b err=%0d line=%0d trunc=%0b",
                 $time, what, got.token_kind, got.token_char, got.last_of_token,
                 got.error_code, got.line_number, got.word_truncated);
    endfunction

    function void check_char(stt_pkg::t_out_item got);
        stt_pkg::t_out_item want;
        string diff;
        if (expected_chars.size() == 0) begin
            report("unexpected transaction", 1'b0, got, got);
            return;
        end
        want = expected_chars.pop_front();
        checked++;
        diff = "";
        if (got.token_kind !== want.token_kind) diff = {diff, " kind"};
        if (got.token_char !== want.token_char) diff = {diff, " char"};
        if (got.last_of_token !== want.last_of_token) diff = {diff, " last"};
        if (got.error_code !== want.error_code) diff = {diff, " err"};
        if (got.line_number !== want.line_number) diff = {diff, " line"};
        if (got.word_truncated !== want.word_truncated) diff = {diff, " trunc"};
        if (diff != "") report({"mismatch in", diff}, 1'b1, want, got);
    endfunction
endclass

module source_text_tokenizer_tb;

    localparam logic [2:0] ADDR_WORD_KEEP = 3'(4 * stt_pkg::REG_WORD_KEEP);
    localparam int SETTLE_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 14;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    stt_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    stt_pkg::t_out_item o_out_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    token_checker board;
    logic [7:0]   text_q[$];
    bit           allow_in_gap = 1'b0;
    logic         allow_out_stall = 1'b0;
    logic [3:0]   out_hold = '0;
    logic [3:0]   mid_keep;
    string        ending_name;

    source_text_tokenizer #(
        .TOKEN_CHARS(MAX_CHARS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check each accepted transaction, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_char(o_out_item);
        if (!i_rst_n || !allow_out_stall) begin
            i_out_stall <= 1'b0;
            out_hold <= '0;
        end else if (out_hold != 0) begin
            i_out_stall <= 1'b1;
            out_hold <= out_hold - 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            out_hold <= 4'($urandom_range(0, 13));
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eoi);
        stt_pkg::t_in_item it;
        int unsigned gap;
        it.source_byte = b;
        it.end_of_input = eoi;
        gap = 0;
        if (allow_in_gap && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.predict_item(it);
    endtask

    task automatic send_text();
        while (text_q.size() != 0) send_item(text_q.pop_front(), 1'b0);
    endtask

    // hold the sender until every expected transaction is out, then let it settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.busy());
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep(input logic [3:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_WORD_KEEP;
        pwdata <= {($urandom_range(0, 1) != 0) ? 28'($urandom()) : 28'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_keep(v);
    endtask

    function automatic void add_byte(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return stt_pkg::CH_NEWLINE;
            3: return CH_VTAB;
            4: return CH_FFEED;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void add_chars(string s);
        int i;
        for (i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // single underscores only, never at the end
    function automatic void add_word(int unsigned len);
        bit us;
        int unsigned i;
        us = 1'b0;
        add_byte("a" + 8'($urandom_range(0, 25)));
        for (i = 1; i < len; i++) begin
            if (!us && i + 1 < len && $urandom_range(0, 4) == 0) begin
                add_byte(stt_pkg::CH_US);
                us = 1'b1;
            end else begin
                us = 1'b0;
                if ($urandom_range(0, 2) == 0) add_byte("0" + 8'($urandom_range(0, 9)));
                else add_byte("a" + 8'($urandom_range(0, 25)));
            end
        end
    endfunction

    function automatic void add_number(int unsigned len);
        repeat (len) add_byte("0" + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_special();
        case ($urandom_range(0, 6))
            0: add_byte(":");
            1: add_byte(",");
            2: add_byte(";");
            3: add_byte("=");
            4: add_byte("+");
            5: add_byte("-");
            default: add_byte(".");
        endcase
    endfunction

    function automatic void add_comment_body(int unsigned len);
        logic [7:0] b;
        repeat (len) begin
            do b = 8'($urandom()); while (b == stt_pkg::CH_RBRACE || b == stt_pkg::CH_DOLLAR);
            add_byte(b);
        end
    endfunction

    // well-formed text with random content; two numbers never touch
    task automatic random_text(input int unsigned count);
        bit last_num;
        last_num = 1'b0;
        while (text_q.size() < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    add_word(($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                                         : $urandom_range(1, 6));
                    last_num = 1'b0;
                end
                3, 4: begin
                    if (last_num) add_byte(pick_space());
                    add_number(($urandom_range(0, 3) == 0) ? MAX_CHARS : $urandom_range(1, 5));
                    last_num = 1'b1;
                end
                5, 6: begin
                    add_special();
                    last_num = 1'b0;
                end
                7: begin
                    add_byte(stt_pkg::CH_LBRACE);
                    add_comment_body($urandom_range(0, 6));
                    add_byte(stt_pkg::CH_RBRACE);
                    last_num = 1'b0;
                end
                default: begin
                    add_byte(pick_space());
                    last_num = 1'b0;
                end
            endcase
            if ($urandom_range(0, 1) == 0) begin
                add_byte(pick_space());
                last_num = 1'b0;
            end
        end
        // leave the scanner between tokens
        add_byte(CH_SPACE);
        send_text();
    endtask

    task automatic random_phase(input logic [3:0] keep_value);
        drain_results();
        write_keep(keep_value);
        allow_in_gap = ($urandom_range(0, 3) != 0);
        allow_out_stall <= ($urandom_range(0, 3) != 0);
        random_text(ITEMS_PER_PHASE);
    endtask

    // one terminal case per run: end of input or one of the errors
    task automatic end_stream();
        logic [7:0] b;
        case ($urandom_range(0, 10))
            0: begin
                ending_name = "end flag";
                send_item(8'($urandom()), 1'b1);
            end
            1: begin
                ending_name = "dollar byte";
                send_item(stt_pkg::CH_DOLLAR, 1'b0);
            end
            2: begin
                ending_name = "end flag inside a word";
                add_word(3);
                send_text();
                send_item(8'($urandom()), 1'b1);
            end
            3: begin
                ending_name = "dollar inside a number";
                add_number(4);
                send_text();
                send_item(stt_pkg::CH_DOLLAR, 1'b0);
            end
            4: begin
                ending_name = "end inside a comment";
                add_byte(stt_pkg::CH_LBRACE);
                add_comment_body(2);
                send_text();
                if ($urandom_range(0, 1) != 0) send_item(stt_pkg::CH_DOLLAR, 1'b0);
                else send_item(8'($urandom()), 1'b1);
            end
            5: begin
                ending_name = "brace starting a token";
                send_item(stt_pkg::CH_RBRACE, 1'b0);
            end
            6: begin
                ending_name = "brace right after a token";
                if ($urandom_range(0, 1) != 0) add_word(4);
                else add_number(3);
                send_text();
                send_item(stt_pkg::CH_RBRACE, 1'b0);
            end
            7: begin
                ending_name = "double underscore";
                add_word(2);
                add_byte(stt_pkg::CH_US);
                add_byte(stt_pkg::CH_US);
                send_text();
            end
            8: begin
                ending_name = "trailing underscore";
                add_word(2);
                add_byte(stt_pkg::CH_US);
                if ($urandom_range(0, 1) != 0) add_byte(pick_space());
                else add_special();
                send_text();
            end
            9: begin
                ending_name = "illegal symbol";
                case ($urandom_range(0, 3))
                    0: b = "A" + 8'($urandom_range(0, 25));
                    1: b = 8'($urandom_range(128, 255));
                    2: b = 8'($urandom_range(0, 8));
                    default: b = "!";
                endcase
                send_item(b, 1'b0);
            end
            default: begin
                ending_name = "number too long";
                add_number(MAX_CHARS + 1);
                send_text();
            end
        endcase
        // scanning has stopped, these are dropped
        repeat (4) send_item(8'($urandom()), 1'($urandom()));
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every special, every whitespace, word/number delimiting,
        // comment holding the byte extremes
        allow_in_gap = 1'b0;
        add_chars("z9_y:,;=+-.");
        add_byte(CH_TAB);
        add_chars("7a");
        add_byte(stt_pkg::CH_NEWLINE);
        add_byte(stt_pkg::CH_LBRACE);
        add_byte(stt_pkg::CH_NUL);
        add_byte(CH_TOP);
        add_byte(stt_pkg::CH_RBRACE);
        add_byte(CH_VTAB);
        add_byte(CH_FFEED);
        add_byte(CH_CR);
        add_byte(CH_SPACE);
        send_text();

        mid_keep = 4'($urandom_range(2, 14));
        random_phase(4'd0);
        random_phase(4'd1);
        random_phase(mid_keep);
        random_phase(stt_pkg::KEEP_RESET);

        // last part: no idling on either side
        drain_results();
        allow_in_gap = 1'b0;
        allow_out_stall <= 1'b0;
        random_text(8);
        end_stream();

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.busy());
        repeat (20) @(posedge i_clk);
        $display("run covered %0d source bytes, %0d token transactions checked",
                 board.bytes_seen, board.checked);
        $display("keep lengths 15, 0, 1, %0d, 15; ending: %s", mid_keep, ending_name);
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout, %0d transactions still expected", board.expected_chars.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* source_text_tokenizer.f */
hdl/stt_pkg.sv
hdl/stt_ram.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer.sv
sim/source_text_tokenizer_tb.sv
